>>> hdl/mht_pkg.sv
`default_nettype none
package mht_pkg;

  // Note table geometry
  localparam int NOTE_COUNT = 128;
  localparam int NOTE_AW    = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int VEL_W      = 7;
  localparam int CNT_W      = 8;

  // Held flags are searched in spans of sixteen notes
  localparam int SPAN_W  = 16;
  localparam int SPAN_N  = (NOTE_COUNT + SPAN_W - 1) / SPAN_W;
  localparam int PAD_W   = SPAN_N * SPAN_W;

  // Opcodes
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  // Forwarded command kinds
  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  // Voice routing
  localparam logic [1:0] ROUTE_BOTH   = 2'd0;
  localparam logic [1:0] ROUTE_FIRST  = 2'd1;
  localparam logic [1:0] ROUTE_SECOND = 2'd2;

  // Configuration register indexes
  localparam logic CFG_CHAN_FIRST  = 1'b0;
  localparam logic CFG_CHAN_SECOND = 1'b1;

  // Marker for an empty held set
  localparam logic signed [7:0] NOTE_NONE = -8'sd1;

  typedef struct packed {
    logic signed [7:0] lowest;
    logic signed [7:0] highest;
  } ext_t;

endpackage
`default_nettype wire

>>> hdl/mht_ram.sv
`default_nettype none
module mht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/mht_extremes.sv
`default_nettype none
module mht_extremes (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic [mht_pkg::PAD_W-1:0] held,
  output mht_pkg::ext_t                  ext
);

  logic       any_r [mht_pkg::SPAN_N];
  logic [3:0] lo_r  [mht_pkg::SPAN_N];
  logic [3:0] hi_r  [mht_pkg::SPAN_N];

  function automatic logic [2:0] first8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [2:0] last8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Register occupancy and end positions of each span
  always_ff @(posedge clk) begin
    if (load) begin
      for (int p = 0; p < mht_pkg::SPAN_N; p++) begin
        logic [7:0] l, h;
        l = held[p*mht_pkg::SPAN_W +: 8];
        h = held[p*mht_pkg::SPAN_W + 8 +: 8];
        any_r[p] <= (|l) | (|h);
        lo_r[p]  <= (|l) ? {1'b0, first8(l)} : {1'b1, first8(h)};
        hi_r[p]  <= (|h) ? {1'b1, last8(h)} : {1'b0, last8(l)};
      end
    end
  end

  // Pick the first and last occupied span
  always_comb begin
    ext.lowest  = mht_pkg::NOTE_NONE;
    ext.highest = mht_pkg::NOTE_NONE;
    for (int p = mht_pkg::SPAN_N - 1; p >= 0; p--) begin
      if (any_r[p]) ext.lowest = 8'(p * mht_pkg::SPAN_W + int'(lo_r[p]));
    end
    for (int p = 0; p < mht_pkg::SPAN_N; p++) begin
      if (any_r[p]) ext.highest = 8'(p * mht_pkg::SPAN_W + int'(hi_r[p]));
    end
  end

endmodule
`default_nettype wire

>>> hdl/midi_held_note_tracker.sv
`default_nettype none
// MIDI held-note tracker.
// Input: an event or query transfers at a rising edge where start is high and
// busy is low (opcode, channel, note, velocity on the in_ ports).
// Configuration: cfg_wr_en with cfg_index (0 first voice channel, 1 second
// voice channel) and cfg_wdata writes a register at the edge; write only
// while no item is in flight.
// Result: one per item, shown for exactly one cycle with out_valid high; the
// receiver takes it at the edge that ends that cycle and cannot stall it.
// Path: the result is registered onto the out_ ports after the item passes
// the modify stage and the held-note search stage.
// Issue: busy is high for the cycle after an accept, while the velocity
// memory read of the note is modified and written back; the next item may
// enter while the held-note search finishes.
// Reset: rst_n low at a clock edge clears the held flags, the held count, the
// channel registers and all in-flight items; busy stays high while rst_n is
// low. The velocity memory needs no clearing pass: entries whose held flag is
// clear read as zero.
module midi_held_note_tracker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [3:0]        in_channel,
  input  wire logic [7:0]        in_note,
  input  wire logic [6:0]        in_velocity,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_index,
  input  wire logic [3:0]        cfg_wdata,
  output logic                   out_valid,
  output logic                   out_forward_valid,
  output logic                   out_forward_kind,
  output logic [1:0]             out_voice_route,
  output logic [6:0]             out_forward_note,
  output logic [6:0]             out_forward_velocity,
  output logic [7:0]             out_held_total,
  output logic                   out_note_is_held,
  output logic [6:0]             out_note_level,
  output logic signed [7:0]      out_lowest_note,
  output logic signed [7:0]      out_highest_note
);

  localparam int AW = mht_pkg::NOTE_AW;
  localparam int VW = mht_pkg::VEL_W;

  // Configuration
  logic [3:0] chan_first_r, chan_second_r;

  // Held state
  logic [mht_pkg::NOTE_COUNT-1:0] held_r, held_nxt;
  logic [mht_pkg::CNT_W-1:0]      held_cnt_r, held_cnt_nxt;

  // Stage valids
  logic b_vld_r, c_vld_r, out_valid_r;

  // Captured item
  logic [1:0]    a_opcode_r;
  logic [3:0]    a_chan_r;
  logic [7:0]    a_note_r;
  logic [VW-1:0] a_vel_r;

  // Results waiting for the search
  logic          c_fwd_valid_r, c_fwd_kind_r, c_is_held_r;
  logic [1:0]    c_route_r;
  logic [6:0]    c_fwd_note_r;
  logic [VW-1:0] c_fwd_vel_r, c_level_r;

  // Memory and modify logic
  logic          accept;
  logic [VW-1:0] ram_rdata, stored, new_vel;
  logic          in_rng, is_event, is_on, was_held, wr_en;
  logic [AW-1:0] addr;
  logic [1:0]    route;
  logic          level_held;
  logic [VW-1:0] level;

  mht_pkg::ext_t ext;

  assign busy   = b_vld_r || !rst_n;
  assign accept = start && !busy;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_first_r  <= 4'd0;
      chan_second_r <= 4'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mht_pkg::CFG_CHAN_FIRST:  chan_first_r  <= cfg_wdata;
        mht_pkg::CFG_CHAN_SECOND: chan_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      a_opcode_r <= in_opcode;
      a_chan_r   <= in_channel;
      a_note_r   <= in_note;
      a_vel_r    <= in_velocity;
    end
  end

  mht_ram #(
    .WIDTH (VW),
    .DEPTH (mht_pkg::NOTE_COUNT)
  ) u_vel_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (new_vel),
    .rd_en   (accept),
    .rd_addr (in_note[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // Modify the addressed entry
  always_comb begin
    addr     = a_note_r[AW-1:0];
    in_rng   = {1'b0, a_note_r} < 9'(mht_pkg::NOTE_COUNT);
    is_event = (a_opcode_r == mht_pkg::OP_NOTE_ON) || (a_opcode_r == mht_pkg::OP_NOTE_OFF);
    is_on    = (a_opcode_r == mht_pkg::OP_NOTE_ON) && (a_vel_r != '0);
    was_held = in_rng && held_r[addr];
    stored   = was_held ? ram_rdata : '0;
    new_vel  = is_on ? a_vel_r : '0;
    wr_en    = b_vld_r && in_rng && is_event;

    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    if (wr_en) begin
      held_nxt[addr] = is_on;
      if (is_on && !was_held) begin
        held_cnt_nxt = held_cnt_r + 1'b1;
      end else if (!is_on && was_held && (held_cnt_r != '0)) begin
        held_cnt_nxt = held_cnt_r - 1'b1;
      end
    end

    priority if (chan_first_r == chan_second_r) begin
      route = mht_pkg::ROUTE_BOTH;
    end else if (a_chan_r == chan_first_r) begin
      route = mht_pkg::ROUTE_FIRST;
    end else begin
      route = mht_pkg::ROUTE_SECOND;
    end

    priority if (!in_rng) begin
      level_held = 1'b0;
      level      = '0;
    end else if (is_event) begin
      level_held = is_on;
      level      = new_vel;
    end else begin
      level_held = was_held;
      level      = stored;
    end
  end

  // Update held flags and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      held_cnt_r <= '0;
    end else begin
      held_r     <= held_nxt;
      held_cnt_r <= held_cnt_nxt;
    end
  end

  mht_extremes u_extremes (
    .clk  (clk),
    .load (b_vld_r),
    .held (mht_pkg::PAD_W'(held_nxt)),
    .ext  (ext)
  );

  // Hold the item's results while the search finishes
  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      c_fwd_valid_r <= in_rng && is_event;
      c_fwd_kind_r  <= (in_rng && is_event && !is_on) ? mht_pkg::KIND_OFF : mht_pkg::KIND_ON;
      c_route_r     <= (in_rng && is_event) ? route : mht_pkg::ROUTE_BOTH;
      c_fwd_note_r  <= (in_rng && is_event) ? a_note_r[6:0] : 7'd0;
      c_fwd_vel_r   <= (in_rng && is_event) ? new_vel : '0;
      c_is_held_r   <= level_held;
      c_level_r     <= level;
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_vld_r     <= accept;
      c_vld_r     <= b_vld_r;
      out_valid_r <= c_vld_r;
    end
  end

  // Load the result registers
  always_ff @(posedge clk) begin
    if (c_vld_r) begin
      out_forward_valid    <= c_fwd_valid_r;
      out_forward_kind     <= c_fwd_kind_r;
      out_voice_route      <= c_route_r;
      out_forward_note     <= c_fwd_note_r;
      out_forward_velocity <= c_fwd_vel_r;
      out_held_total       <= held_cnt_r;
      out_note_is_held     <= c_is_held_r;
      out_note_level       <= c_level_r;
      out_lowest_note      <= ext.lowest;
      out_highest_note     <= ext.highest;
    end
  end

  assign out_valid = out_valid_r;

  // Count always matches the held flags
  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r == mht_pkg::CNT_W'($countones(held_r)))
    else $error("held count differs from held flags");

  // Modify stage is followed by search stage
  a_b_to_c: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |=> c_vld_r)
    else $error("search stage missed an item");

  // Strobe only after a search stage
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(c_vld_r))
    else $error("result strobe without an item");

  // No two items occupy the modify stage back to back
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> !$past(b_vld_r))
    else $error("two items in the modify stage back to back");

  // Empty held set reports no extremes
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_held_total == '0)) |->
      ((out_lowest_note == mht_pkg::NOTE_NONE) && (out_highest_note == mht_pkg::NOTE_NONE)))
    else $error("extremes reported with no held note");

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // Opcode 3 has no name in the package; the block treats it as a query
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic              fwd_valid;
    logic              fwd_kind;
    logic [1:0]        route;
    logic [6:0]        fwd_note;
    logic [6:0]        fwd_vel;
    logic [7:0]        held;
    logic              is_held;
    logic [6:0]        level;
    logic signed [7:0] lowest;
    logic signed [7:0] highest;
  } tracker_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_opcode;
  logic [3:0]        in_channel;
  logic [7:0]        in_note;
  logic [6:0]        in_velocity;
  logic              cfg_wr_en;
  logic              cfg_index;
  logic [3:0]        cfg_wdata;
  logic              out_valid;
  logic              out_forward_valid;
  logic              out_forward_kind;
  logic [1:0]        out_voice_route;
  logic [6:0]        out_forward_note;
  logic [6:0]        out_forward_velocity;
  logic [7:0]        out_held_total;
  logic              out_note_is_held;
  logic [6:0]        out_note_level;
  logic signed [7:0] out_lowest_note;
  logic signed [7:0] out_highest_note;

  // Shadow copy of the tracker state and channel registers
  logic [6:0]        vel_table [mht_pkg::NOTE_COUNT];
  logic [7:0]        shadow_total;
  logic [3:0]        chan_first;
  logic [3:0]        chan_second;

  tracker_result_t   pending_results [$];
  int                fail_count = 0;
  bit                burst_mode = 1'b0;

  midi_held_note_tracker dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_channel           (in_channel),
    .in_note              (in_note),
    .in_velocity          (in_velocity),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .out_valid            (out_valid),
    .out_forward_valid    (out_forward_valid),
    .out_forward_kind     (out_forward_kind),
    .out_voice_route      (out_voice_route),
    .out_forward_note     (out_forward_note),
    .out_forward_velocity (out_forward_velocity),
    .out_held_total       (out_held_total),
    .out_note_is_held     (out_note_is_held),
    .out_note_level       (out_note_level),
    .out_lowest_note      (out_lowest_note),
    .out_highest_note     (out_highest_note)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one item to the shadow table and return the result it should produce
  function automatic tracker_result_t predict_tracker(input logic [1:0] op,
                                                      input logic [3:0] chan,
                                                      input logic [7:0] note,
                                                      input logic [6:0] vel);
    tracker_result_t r;
    logic            in_range;
    logic [6:0]      idx;
    r = '0;
    in_range = (note < mht_pkg::NOTE_COUNT);
    idx = note[6:0];
    if (in_range && (op == mht_pkg::OP_NOTE_ON || op == mht_pkg::OP_NOTE_OFF)) begin
      if (op == mht_pkg::OP_NOTE_ON && vel != 7'd0) begin
        if (vel_table[idx] == 7'd0) shadow_total = shadow_total + 8'd1;
        vel_table[idx] = vel;
        r.fwd_kind = mht_pkg::KIND_ON;
        r.fwd_vel = vel;
      end else begin
        // Zero-velocity note on lands here too; releasing an idle note is a no-op
        if (vel_table[idx] != 7'd0) begin
          vel_table[idx] = 7'd0;
          if (shadow_total != 8'd0) shadow_total = shadow_total - 8'd1;
        end
        r.fwd_kind = mht_pkg::KIND_OFF;
      end
      r.fwd_valid = 1'b1;
      r.fwd_note = idx;
      if (chan_first == chan_second) begin
        r.route = mht_pkg::ROUTE_BOTH;
      end else if (chan == chan_first) begin
        r.route = mht_pkg::ROUTE_FIRST;
      end else begin
        r.route = mht_pkg::ROUTE_SECOND;
      end
    end
    r.held = shadow_total;
    if (in_range) begin
      r.is_held = (vel_table[idx] != 7'd0);
      r.level = vel_table[idx];
    end
    r.lowest = mht_pkg::NOTE_NONE;
    r.highest = mht_pkg::NOTE_NONE;
    for (int n = mht_pkg::NOTE_COUNT - 1; n >= 0; n--) begin
      if (vel_table[n] != 7'd0) r.lowest = 8'(n);
    end
    for (int n = 0; n < mht_pkg::NOTE_COUNT; n++) begin
      if (vel_table[n] != 7'd0) r.highest = 8'(n);
    end
    return r;
  endfunction

  function automatic void log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      log_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    end
  endfunction

  // Mostly short gaps, a few long ones; none at all in burst stretches
  function automatic int draw_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Compare every result strobe against the oldest outstanding prediction
  always @(posedge clk) begin : check_results
    tracker_result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          log_failure("result strobe with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("forward_valid", 8'(want.fwd_valid), 8'(out_forward_valid));
          check_field("forward_kind", 8'(want.fwd_kind), 8'(out_forward_kind));
          check_field("voice_route", 8'(want.route), 8'(out_voice_route));
          check_field("forward_note", 8'(want.fwd_note), 8'(out_forward_note));
          check_field("forward_velocity", 8'(want.fwd_vel), 8'(out_forward_velocity));
          check_field("held_total", want.held, out_held_total);
          check_field("note_is_held", 8'(want.is_held), 8'(out_note_is_held));
          check_field("note_level", 8'(want.level), 8'(out_note_level));
          check_field("lowest_note", want.lowest, out_lowest_note);
          check_field("highest_note", want.highest, out_highest_note);
        end
      end else if (out_valid !== 1'b0) begin
        log_failure("out_valid unknown");
      end
    end
  end

  // Hold start and the fields until the transfer, then record the prediction
  task automatic send_event(input logic [1:0] op, input logic [3:0] chan,
                            input logic [7:0] note, input logic [6:0] vel);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_opcode   <= op;
    in_channel  <= chan;
    in_note     <= note;
    in_velocity <= vel;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_tracker(op, chan, note, vel));
  endtask

  // Drop start and wait for every outstanding result, then idle with start low
  task automatic wait_idle();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      log_failure($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // Write both channel registers back to back; call only while idle
  task automatic set_channels(input logic [3:0] first_ch, input logic [3:0] second_ch);
    cfg_wr_en <= 1'b1;
    cfg_index <= mht_pkg::CFG_CHAN_FIRST;
    cfg_wdata <= first_ch;
    @(posedge clk);
    cfg_index <= mht_pkg::CFG_CHAN_SECOND;
    cfg_wdata <= second_ch;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chan_first = first_ch;
    chan_second = second_ch;
    @(posedge clk);
  endtask

  // Field extremes, every opcode and the corner cases, with reset channels
  task automatic test_directed();
    send_event(mht_pkg::OP_QUERY, 4'd0, 8'd0, 7'd0);
    send_event(mht_pkg::OP_NOTE_ON, 4'd0, 8'd0, 7'd127);
    send_event(mht_pkg::OP_NOTE_ON, 4'd15, 8'd127, 7'd1);
    send_event(mht_pkg::OP_QUERY, 4'd15, 8'd127, 7'd127);
    send_event(mht_pkg::OP_NOTE_ON, 4'd0, 8'd0, 7'd64);
    send_event(mht_pkg::OP_NOTE_ON, 4'd3, 8'd60, 7'd0);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd3, 8'd100, 7'd0);
    send_event(mht_pkg::OP_NOTE_ON, 4'd0, 8'd128, 7'd127);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd15, 8'd255, 7'd127);
    send_event(mht_pkg::OP_QUERY, 4'd0, 8'd200, 7'd0);
    send_event(OP_UNUSED, 4'd15, 8'd0, 7'd127);
    send_event(OP_UNUSED, 4'd0, 8'd255, 7'd0);
    send_event(mht_pkg::OP_NOTE_ON, 4'd15, 8'd60, 7'd100);
    send_event(mht_pkg::OP_NOTE_ON, 4'd15, 8'd60, 7'd0);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd0, 8'd0, 7'd127);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd0, 8'd127, 7'd0);
    send_event(mht_pkg::OP_QUERY, 4'd0, 8'd0, 7'd0);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd0, 8'd5, 7'd0);
    send_event(mht_pkg::OP_NOTE_ON, 4'd15, 8'd64, 7'd127);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd15, 8'd64, 7'd85);
    wait_idle();
  endtask

  // Route to the first voice, the second, the fallback to the second, and both when the channels match
  task automatic test_routing();
    set_channels(4'd3, 4'd12);
    send_event(mht_pkg::OP_NOTE_ON, 4'd3, 8'd40, 7'd90);
    send_event(mht_pkg::OP_NOTE_ON, 4'd12, 8'd41, 7'd91);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd7, 8'd40, 7'd0);
    send_event(mht_pkg::OP_QUERY, 4'd3, 8'd41, 7'd0);
    wait_idle();
    set_channels(4'd0, 4'd15);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd0, 8'd41, 7'd0);
    send_event(mht_pkg::OP_NOTE_ON, 4'd15, 8'd10, 7'd42);
    send_event(mht_pkg::OP_NOTE_ON, 4'd8, 8'd11, 7'd0);
    wait_idle();
    set_channels(4'd15, 4'd0);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd15, 8'd10, 7'd0);
    send_event(mht_pkg::OP_NOTE_ON, 4'd0, 8'd20, 7'd21);
    wait_idle();
    set_channels(4'd9, 4'd9);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd2, 8'd20, 7'd0);
    send_event(mht_pkg::OP_NOTE_ON, 4'd9, 8'd30, 7'd31);
    send_event(mht_pkg::OP_NOTE_OFF, 4'd9, 8'd30, 7'd31);
    wait_idle();
  endtask

  // Fill every note, re-strike and query a full table, then release them all
  task automatic test_full_table();
    logic [7:0] note;
    set_channels(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    burst_mode = 1'b1;
    for (int k = 0; k < mht_pkg::NOTE_COUNT; k++) begin
      if (k == mht_pkg::NOTE_COUNT / 2) burst_mode = 1'b0;
      note = 8'((k * 37) % mht_pkg::NOTE_COUNT);
      send_event(mht_pkg::OP_NOTE_ON, 4'($urandom_range(0, 15)), note,
                 7'($urandom_range(1, 127)));
    end
    send_event(mht_pkg::OP_QUERY, 4'd0, 8'd0, 7'd0);
    send_event(mht_pkg::OP_QUERY, 4'd15, 8'd127, 7'd0);
    send_event(mht_pkg::OP_QUERY, 4'd5, 8'd128, 7'd0);
    send_event(mht_pkg::OP_NOTE_ON, 4'd5, 8'd77, 7'($urandom_range(1, 127)));
    for (int k = 0; k < mht_pkg::NOTE_COUNT; k++) begin
      if (k == mht_pkg::NOTE_COUNT / 2) burst_mode = 1'b1;
      note = 8'((k * 53) % mht_pkg::NOTE_COUNT);
      send_event(mht_pkg::OP_NOTE_OFF, 4'($urandom_range(0, 15)), note,
                 7'($urandom_range(0, 127)));
    end
    burst_mode = 1'b0;
    // Release once more with the count already at zero
    send_event(mht_pkg::OP_NOTE_OFF, 4'd1, 8'd33, 7'd0);
    wait_idle();
  endtask

  // Chord-like traffic around a moving window, plus noise and ignored notes
  task automatic random_event(input int base);
    int         r;
    logic [1:0] op;
    logic [3:0] chan;
    logic [7:0] note;
    logic [6:0] vel;
    r = $urandom_range(0, 99);
    if (r < 48) op = mht_pkg::OP_NOTE_ON;
    else if (r < 85) op = mht_pkg::OP_NOTE_OFF;
    else if (r < 95) op = mht_pkg::OP_QUERY;
    else op = OP_UNUSED;
    r = $urandom_range(0, 99);
    if (r < 70) note = 8'(base + $urandom_range(0, 23));
    else if (r < 85) note = 8'($urandom_range(0, mht_pkg::NOTE_COUNT - 1));
    else note = 8'($urandom_range(128, 255));
    if (op == mht_pkg::OP_NOTE_ON && $urandom_range(0, 9) != 0) begin
      vel = 7'($urandom_range(1, 127));
    end else begin
      vel = 7'($urandom_range(0, 127));
    end
    r = $urandom_range(0, 9);
    if (r < 4) chan = chan_first;
    else if (r < 7) chan = chan_second;
    else chan = 4'($urandom_range(0, 15));
    send_event(op, chan, note, vel);
  endtask

  task automatic test_random_play();
    int base;
    base = 0;
    for (int phase = 0; phase < 5; phase++) begin
      unique case (phase)
        0: set_channels(4'd0, 4'd0);
        1: set_channels(4'd0, 4'd15);
        2: set_channels(4'd15, 4'd15);
        3: set_channels(4'd15, 4'd0);
        default: set_channels(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      for (int k = 0; k < 180; k++) begin
        if (k % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        if (k % 60 == 0) base = $urandom_range(0, mht_pkg::NOTE_COUNT - 24);
        random_event(base);
      end
      burst_mode = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_opcode   <= mht_pkg::OP_QUERY;
    in_channel  <= 4'd0;
    in_note     <= 8'd0;
    in_velocity <= 7'd0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= mht_pkg::CFG_CHAN_FIRST;
    cfg_wdata   <= 4'd0;
    for (int n = 0; n < mht_pkg::NOTE_COUNT; n++) vel_table[n] = 7'd0;
    shadow_total = 8'd0;
    chan_first   = 4'd0;
    chan_second  = 4'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_routing();
    test_full_table();
    test_random_play();

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
